// ===== sv/mcar_pkg.sv =====
// ----------------------------------------------------------------------------
// mcar_pkg
// Shared types and constants for the multi-card configuration controller.
// ----------------------------------------------------------------------------
package mcar_pkg;

  // Event codes
  typedef enum logic [2:0] {
    OP_LISTEN    = 3'd0,
    OP_CONFIGURE = 3'd1,
    OP_FEEDBACK  = 3'd2,
    OP_POLL      = 3'd3,
    OP_START     = 3'd4,
    OP_STOP      = 3'd5
  } opcode_t;

  // Feedback types
  localparam logic [1:0] FB_READY = 2'd1;
  localparam logic [1:0] FB_ACK   = 2'd2;

  // Send kinds
  localparam logic [1:0] KIND_CONFIG = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUNDS  = 2'd2;

  // Configuration reset values
  localparam logic [5:0]  CARD_COUNT_RST  = 6'd32;
  localparam logic [31:0] ACK_TIMEOUT_RST = 32'd1000000000;
  localparam logic [3:0]  MAX_ROUNDS_RST  = 4'd4;

  // Card count compare width (holds up to 64)
  localparam int unsigned CNT_W = 7;

  // Round counter saturation value
  localparam logic [3:0] ROUNDS_MAX = 4'hF;

  // Control flags of the controller
  typedef struct packed {
    logic       listening;
    logic       configured;
    logic       configuring;
    logic       await_ack;
    logic [3:0] rounds;
  } ctl_t;

endpackage

// ===== sv/mcar_step.sv =====
// ----------------------------------------------------------------------------
// mcar_step
// Next-state and result logic for one event of the configuration controller.
// ----------------------------------------------------------------------------
module mcar_step #(
  parameter int MAX_CARDS     = 32,
  parameter int COMMAND_WIDTH = 32
) (
  // configuration
  input  logic [5:0]               card_count,
  input  logic [31:0]              ack_timeout,
  input  logic [3:0]               max_rounds,
  // current state
  input  mcar_pkg::ctl_t           ctl,
  input  logic [63:0]              deadline,
  input  logic [MAX_CARDS-1:0]     acked,
  input  logic [MAX_CARDS-1:0]     ready,
  input  logic [COMMAND_WIDTH-1:0] stored,
  // event
  input  logic [2:0]               opcode,
  input  logic                     listen_value,
  input  logic [COMMAND_WIDTH-1:0] command_word,
  input  logic                     wait_ack,
  input  logic [62:0]              now,
  input  logic [5:0]               card_index,
  input  logic [1:0]               feedback_type,
  input  logic                     send_ok,
  // next state
  output mcar_pkg::ctl_t           ctl_next,
  output logic [63:0]              deadline_next,
  output logic [MAX_CARDS-1:0]     acked_next,
  output logic [MAX_CARDS-1:0]     ready_next,
  output logic [COMMAND_WIDTH-1:0] stored_next,
  // result
  output logic                     accepted,
  output logic                     send_valid,
  output logic [1:0]               send_kind,
  output logic [COMMAND_WIDTH-1:0] send_command,
  output logic [MAX_CARDS-1:0]     target_mask
);

  logic [mcar_pkg::CNT_W-1:0] active;
  logic [MAX_CARDS-1:0]       all_mask;
  logic [MAX_CARDS-1:0]       card_bit;
  logic                       card_ok;
  logic [63:0]                due_time;
  logic                       timed_out;
  logic                       do_round;
  logic                       is_cfg;
  logic [MAX_CARDS-1:0]       r_acked;
  logic [3:0]                 r_rounds;
  logic                       r_await;
  logic [COMMAND_WIDTH-1:0]   r_cmd;
  logic [MAX_CARDS-1:0]       missing;
  logic [MAX_CARDS-1:0]       ack_set;

  // Active card count, clamped to the number of card slots
  always_comb begin
    if ({1'b0, card_count} > mcar_pkg::CNT_W'(MAX_CARDS)) begin
      active = mcar_pkg::CNT_W'(MAX_CARDS);
    end else begin
      active = {1'b0, card_count};
    end
  end

  // All-cards mask and one-hot of the reporting card
  always_comb begin
    for (int i = 0; i < MAX_CARDS; i++) begin
      all_mask[i] = (mcar_pkg::CNT_W'(i) < active);
      card_bit[i] = (mcar_pkg::CNT_W'(card_index) == mcar_pkg::CNT_W'(i));
    end
  end

  assign card_ok   = ({1'b0, card_index} < active);
  assign due_time  = {1'b0, now} + {32'd0, ack_timeout};
  assign timed_out = ({1'b0, now} >= deadline);

  // Round inputs: a configure starts from a cleared round
  assign is_cfg   = (opcode == mcar_pkg::OP_CONFIGURE);
  assign r_acked  = is_cfg ? '0 : acked;
  assign r_rounds = is_cfg ? 4'd0 : ctl.rounds;
  assign r_await  = is_cfg ? wait_ack : ctl.await_ack;
  assign r_cmd    = is_cfg ? command_word : stored;
  assign missing  = all_mask & ~r_acked;
  assign ack_set  = acked | card_bit;

  assign do_round = (is_cfg && ctl.listening) ||
                    ((opcode == mcar_pkg::OP_POLL) && ctl.configuring && timed_out &&
                     (ctl.rounds < max_rounds));

  // Event handling
  always_comb begin
    ctl_next      = ctl;
    deadline_next = deadline;
    acked_next    = acked;
    ready_next    = ready;
    stored_next   = stored;
    accepted      = 1'b0;
    send_valid    = 1'b0;
    send_kind     = mcar_pkg::KIND_CONFIG;
    send_command  = '0;
    target_mask   = '0;

    case (opcode)
      mcar_pkg::OP_LISTEN: begin
        ctl_next.listening   = listen_value;
        ctl_next.configured  = 1'b0;
        ctl_next.configuring = 1'b0;
        ctl_next.rounds      = 4'd0;
        deadline_next        = '0;
        ready_next           = '0;
        acked_next           = '0;
      end
      mcar_pkg::OP_CONFIGURE: begin
        if (ctl.listening) begin
          stored_next          = command_word;
          ctl_next.await_ack   = wait_ack;
          ctl_next.configured  = 1'b0;
          ctl_next.configuring = 1'b1;
          ctl_next.rounds      = 4'd0;
          acked_next           = '0;
        end
      end
      mcar_pkg::OP_FEEDBACK: begin
        if (card_ok) begin
          if (feedback_type == mcar_pkg::FB_READY) begin
            ready_next = ready | card_bit;
          end
          if (feedback_type == mcar_pkg::FB_ACK) begin
            acked_next = ack_set;
            if (ctl.configuring && ((ack_set & all_mask) == all_mask)) begin
              ctl_next.configured  = 1'b1;
              ctl_next.configuring = 1'b0;
            end
          end
        end
      end
      mcar_pkg::OP_POLL: begin
        if (ctl.configuring && timed_out && (ctl.rounds >= max_rounds)) begin
          ctl_next.configuring = 1'b0;
        end
      end
      mcar_pkg::OP_START, mcar_pkg::OP_STOP: begin
        if (ctl.listening && ((opcode == mcar_pkg::OP_STOP) || ctl.configured)) begin
          send_valid  = 1'b1;
          send_kind   = (opcode == mcar_pkg::OP_START) ? mcar_pkg::KIND_START
                                                       : mcar_pkg::KIND_STOP;
          target_mask = all_mask;
          accepted    = send_ok;
        end
      end
      default: begin
      end
    endcase

    // Send round to cards still missing an acknowledgement; complete if none is missing
    if (do_round) begin
      if (missing == '0) begin
        ctl_next.configured  = 1'b1;
        ctl_next.configuring = 1'b0;
        accepted             = is_cfg;
      end else begin
        ctl_next.rounds = (r_rounds == mcar_pkg::ROUNDS_MAX) ? r_rounds : r_rounds + 4'd1;
        send_valid      = 1'b1;
        send_kind       = mcar_pkg::KIND_CONFIG;
        send_command    = r_cmd;
        target_mask     = missing;
        if (!send_ok) begin
          ctl_next.configuring = 1'b0;
        end else if (!r_await) begin
          acked_next           = all_mask;
          ctl_next.configured  = 1'b1;
          ctl_next.configuring = 1'b0;
          accepted             = is_cfg;
        end else begin
          deadline_next = due_time;
          accepted      = is_cfg;
        end
      end
    end
  end

endmodule

// ===== sv/multicard_config_ack_retry.sv =====
// One event per clock is taken at the input; its result moves from the input
// register into the output register (one pass of mask logic, one 64-bit add
// and one 64-bit compare lie between them). A waiting result does not stop
// one more event from entering an empty input register; the input stalls
// only while both registers hold work and the output is stalled. Configuration
// writes take effect at once and must be made only while no event is in flight.
// ----------------------------------------------------------------------------
// multicard_config_ack_retry
// Broadcast configuration controller with per-card acknowledgement and
// timed resend rounds.
// ----------------------------------------------------------------------------
module multicard_config_ack_retry #(
  parameter int MAX_CARDS     = 32,
  parameter int COMMAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     cfg_we,
  input  logic [mcar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  // event channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               opcode,
  input  logic                     listen_value,
  input  logic [COMMAND_WIDTH-1:0] command_word,
  input  logic                     wait_ack,
  input  logic [62:0]              now,
  input  logic [5:0]               card_index,
  input  logic [1:0]               feedback_type,
  input  logic                     send_ok,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     accepted,
  output logic                     send_valid,
  output logic [1:0]               send_kind,
  output logic [COMMAND_WIDTH-1:0] send_command,
  output logic [MAX_CARDS-1:0]     target_mask,
  output logic                     is_configured,
  output logic                     is_configuring,
  output logic [MAX_CARDS-1:0]     ready_mask,
  output logic [MAX_CARDS-1:0]     ack_mask,
  output logic [3:0]               rounds_used
);

  // configuration registers
  logic [5:0]  card_count;
  logic [31:0] ack_timeout;
  logic [3:0]  max_rounds;

  // controller state
  mcar_pkg::ctl_t           ctl;
  logic [63:0]              deadline;
  logic [MAX_CARDS-1:0]     acked;
  logic [MAX_CARDS-1:0]     ready;
  logic [COMMAND_WIDTH-1:0] stored;

  // input register
  logic                     in_full;
  logic [2:0]               q_opcode;
  logic                     q_listen_value;
  logic [COMMAND_WIDTH-1:0] q_command_word;
  logic                     q_wait_ack;
  logic [62:0]              q_now;
  logic [5:0]               q_card_index;
  logic [1:0]               q_feedback_type;
  logic                     q_send_ok;

  // step outputs
  mcar_pkg::ctl_t           ctl_next;
  logic [63:0]              deadline_next;
  logic [MAX_CARDS-1:0]     acked_next;
  logic [MAX_CARDS-1:0]     ready_next;
  logic [COMMAND_WIDTH-1:0] stored_next;
  logic                     accepted_next;
  logic                     send_valid_next;
  logic [1:0]               send_kind_next;
  logic [COMMAND_WIDTH-1:0] send_command_next;
  logic [MAX_CARDS-1:0]     target_mask_next;

  logic take;
  logic advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      card_count  <= mcar_pkg::CARD_COUNT_RST;
      ack_timeout <= mcar_pkg::ACK_TIMEOUT_RST;
      max_rounds  <= mcar_pkg::MAX_ROUNDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mcar_pkg::CFG_CARD_COUNT:  card_count  <= cfg_data[5:0];
        mcar_pkg::CFG_ACK_TIMEOUT: ack_timeout <= cfg_data;
        mcar_pkg::CFG_MAX_ROUNDS:  max_rounds  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_opcode        <= opcode;
      q_listen_value  <= listen_value;
      q_command_word  <= command_word;
      q_wait_ack      <= wait_ack;
      q_now           <= now;
      q_card_index    <= card_index;
      q_feedback_type <= feedback_type;
      q_send_ok       <= send_ok;
    end
  end

  mcar_step #(
    .MAX_CARDS     (MAX_CARDS),
    .COMMAND_WIDTH (COMMAND_WIDTH)
  ) u_step (
    .card_count    (card_count),
    .ack_timeout   (ack_timeout),
    .max_rounds    (max_rounds),
    .ctl           (ctl),
    .deadline      (deadline),
    .acked         (acked),
    .ready         (ready),
    .stored        (stored),
    .opcode        (q_opcode),
    .listen_value  (q_listen_value),
    .command_word  (q_command_word),
    .wait_ack      (q_wait_ack),
    .now           (q_now),
    .card_index    (q_card_index),
    .feedback_type (q_feedback_type),
    .send_ok       (q_send_ok),
    .ctl_next      (ctl_next),
    .deadline_next (deadline_next),
    .acked_next    (acked_next),
    .ready_next    (ready_next),
    .stored_next   (stored_next),
    .accepted      (accepted_next),
    .send_valid    (send_valid_next),
    .send_kind     (send_kind_next),
    .send_command  (send_command_next),
    .target_mask   (target_mask_next)
  );

  // Controller state update
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= '0;
      deadline <= '0;
      acked    <= '0;
      ready    <= '0;
      stored   <= '0;
    end else if (advance) begin
      ctl      <= ctl_next;
      deadline <= deadline_next;
      acked    <= acked_next;
      ready    <= ready_next;
      stored   <= stored_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      accepted       <= accepted_next;
      send_valid     <= send_valid_next;
      send_kind      <= send_kind_next;
      send_command   <= send_command_next;
      target_mask    <= target_mask_next;
      is_configured  <= ctl_next.configured;
      is_configuring <= ctl_next.configuring;
      ready_mask     <= ready_next;
      ack_mask       <= acked_next;
      rounds_used    <= ctl_next.rounds;
    end
  end

  // Checks
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.configured && ctl.configuring))
    else $error("configured and configuring both set");

  a_cfg_needs_listen: assert property (@(posedge clk) disable iff (rst)
    (ctl.configuring || ctl.configured) |-> ctl.listening)
    else $error("configuration flag set while not listening");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(ctl))
    else $error("controller state changed without an event");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed event produced no result");

endmodule
